// ===== hdl/mx4_pkg.sv =====
// Shared types and constants for the 4x4 matrix add/subtract/multiply block.
// Used by mx4_ctrl, mx4_dpath and matrix4_add_sub_mul. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mx4_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int MODE_W = 2;

  // Mode register bit positions; mode 3 decodes as product (high bit only)
  localparam int MODE_SUB_BIT = 0;
  localparam int MODE_MUL_BIT = 1;

  localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic             step_first;
    logic             step_last;
    logic             op_mul;
    logic             op_sub;
    logic [IDX_W-1:0] elem_index;
    logic             elem_last;
  } mx4_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/mx4_ctrl.sv =====
// Controller: load sequencing, mode register and per-element step issue.
// Depends on mx4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mx4_ctrl #(
  parameter int DIM = 4
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [mx4_pkg::MODE_W-1:0]      cfg_data,
  input  wire                             elem_done,
  output mx4_pkg::mx4_cmd_t               cmd,
  output logic [$clog2(DIM*DIM)-1:0]      wr_addr,
  output logic [$clog2(DIM*DIM)-1:0]      rd_left_addr,
  output logic [$clog2(DIM*DIM)-1:0]      rd_right_addr
);

  localparam int CELLS = DIM * DIM;
  localparam int CNT_W = $clog2(CELLS);
  localparam int R_W   = $clog2(DIM);

  typedef enum logic [1:0] {S_LOAD, S_ISSUE, S_WAIT} state_t;

  state_t                      state;
  logic [CNT_W-1:0]            load_count;
  logic [R_W-1:0]              row;
  logic [R_W-1:0]              col;
  logic [R_W-1:0]              k;
  logic [mx4_pkg::MODE_W-1:0]  mode_reg;
  logic                        op_mul;
  logic                        op_sub;

  logic [CNT_W-1:0]            elem_addr;
  logic [CNT_W+mx4_pkg::IDX_W-1:0] elem_ext;
  logic                        step_last;
  logic                        elem_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_LOAD);
  assign wr_addr   = load_count;

  always_comb begin
    elem_addr = CNT_W'(row) * CNT_W'(DIM) + CNT_W'(col);
    elem_ext  = (CNT_W + mx4_pkg::IDX_W)'(elem_addr);
    step_last = op_mul ? (k == R_W'(DIM - 1)) : 1'b1;
    elem_last = (row == R_W'(DIM - 1)) && (col == R_W'(DIM - 1));
    // product walks row of left and column of right; add/sub reads one cell
    rd_left_addr  = op_mul ? CNT_W'(row) * CNT_W'(DIM) + CNT_W'(k) : elem_addr;
    rd_right_addr = op_mul ? CNT_W'(k) * CNT_W'(DIM) + CNT_W'(col) : elem_addr;

    cmd.wr_en      = in_valid && (state == S_LOAD);
    cmd.rd_en      = (state == S_ISSUE);
    cmd.step_first = (k == '0);
    cmd.step_last  = step_last;
    cmd.op_mul     = op_mul;
    cmd.op_sub     = op_sub;
    cmd.elem_index = elem_ext[mx4_pkg::IDX_W-1:0];
    cmd.elem_last  = elem_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      k          <= '0;
      mode_reg   <= mx4_pkg::MODE_MUL;
      op_mul     <= 1'b0;
      op_sub     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_reg <= cfg_data;
      end
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (load_count == CNT_W'(CELLS - 1)) begin
              // mode is sampled when the last element arrives
              load_count <= '0;
              op_mul     <= mode_reg[mx4_pkg::MODE_MUL_BIT];
              op_sub     <= mode_reg[mx4_pkg::MODE_SUB_BIT];
              row        <= '0;
              col        <= '0;
              k          <= '0;
              state      <= S_ISSUE;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        S_ISSUE: begin
          if (step_last) begin
            k     <= '0;
            state <= S_WAIT;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_WAIT: begin
          if (elem_done) begin
            if (elem_last) begin
              state <= S_LOAD;
            end else begin
              if (col == R_W'(DIM - 1)) begin
                col <= '0;
                row <= row + 1'b1;
              end else begin
                col <= col + 1'b1;
              end
              state <= S_ISSUE;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mx4_dpath.sv =====
// Datapath: operand stores, shared multiply-accumulate pipeline, saturation
// and output register. Depends on mx4_pkg; driven by mx4_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module mx4_dpath #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire  signed [mx4_pkg::DATA_W-1:0] left_value,
  input  wire  signed [mx4_pkg::DATA_W-1:0] right_value,
  input  mx4_pkg::mx4_cmd_t                 cmd,
  input  wire  [$clog2(DIM*DIM)-1:0]        wr_addr,
  input  wire  [$clog2(DIM*DIM)-1:0]        rd_left_addr,
  input  wire  [$clog2(DIM*DIM)-1:0]        rd_right_addr,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [mx4_pkg::IDX_W-1:0]         element_index,
  output logic signed [mx4_pkg::DATA_W-1:0] result_value,
  output logic                              saturated,
  output logic                              last_element,
  output logic                              elem_done
);

  localparam int CELLS = DIM * DIM;
  localparam int ACC_W = 65 + $clog2(DIM);
  localparam int DW    = mx4_pkg::DATA_W;

  logic [DW-1:0]         left_mem  [CELLS];
  logic [DW-1:0]         right_mem [CELLS];

  logic signed [DW-1:0]  left_rd;
  logic signed [DW-1:0]  right_rd;
  logic                  v1, f1, l1;
  logic signed [63:0]    prod;
  logic                  v2, f2, l2;
  logic signed [ACC_W-1:0] acc;
  logic                  v3;

  logic signed [63:0]    mul_res;
  logic signed [63:0]    term;
  logic                  clip;

  // operand stores
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      left_mem[wr_addr]  <= left_value;
      right_mem[wr_addr] <= right_value;
    end
    if (cmd.rd_en) begin
      left_rd  <= left_mem[rd_left_addr];
      right_rd <= right_mem[rd_right_addr];
    end
  end

  assign mul_res = left_rd * right_rd;
  // floor of the product; add/sub result passes straight through
  assign term = cmd.op_mul ? (prod >>> FRAC_BITS) : prod;
  assign clip = !((&acc[ACC_W-1:DW-1]) || !(|acc[ACC_W-1:DW-1]));
  assign elem_done = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      v3 <= v2 && l2;
      if (v3) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    f1 <= cmd.step_first;
    l1 <= cmd.step_last;
    f2 <= f1;
    l2 <= l1;
    if (v1) begin
      if (cmd.op_mul) begin
        prod <= mul_res;
      end else if (cmd.op_sub) begin
        prod <= 64'(left_rd) - 64'(right_rd);
      end else begin
        prod <= 64'(left_rd) + 64'(right_rd);
      end
    end
    if (v2) begin
      acc <= (f2 ? '0 : acc) + ACC_W'(term);
    end
    if (v3) begin
      element_index <= cmd.elem_index;
      last_element  <= cmd.elem_last;
      saturated     <= clip;
      if (clip) begin
        result_value <= acc[ACC_W-1] ? mx4_pkg::Q_MIN : mx4_pkg::Q_MAX;
      end else begin
        result_value <= acc[DW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/matrix4_add_sub_mul.sv =====
// Top level of the DIM x DIM matrix add/subtract/multiply block.
// Instantiates mx4_ctrl and mx4_dpath; uses mx4_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Loads two DIM x DIM signed fixed-point matrices (FRAC_BITS fraction bits)
// one element pair per transaction, row-major, one per cycle. After the last
// pair it emits DIM*DIM results in row-major order, last_element on the final
// one; input is not taken while a run is being computed and delivered.
// operation_mode (cfg_data, reset 2) is sampled with the last input element:
// 0 add, 1 subtract, 2 or 3 matrix product. Products are floored to the
// fixed-point grid, summed from zero and saturated to 32 bits, with
// saturated flagging a clipped element. A single multiply-accumulate unit
// does every product: for each result the controller reads one row of the
// left and one column of the right matrix, then the multiply, accumulate and
// clip/output-register stages follow, and the next result is issued only after
// the previous one has been handed off; add and subtract read one cell per result.
module matrix4_add_sub_mul #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  signed [mx4_pkg::DATA_W-1:0] left_value,
  input  wire  signed [mx4_pkg::DATA_W-1:0] right_value,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [mx4_pkg::IDX_W-1:0]         element_index,
  output logic signed [mx4_pkg::DATA_W-1:0] result_value,
  output logic                              saturated,
  output logic                              last_element,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [mx4_pkg::MODE_W-1:0]        cfg_data
);

  localparam int CNT_W = $clog2(DIM * DIM);

  mx4_pkg::mx4_cmd_t  cmd;
  logic [CNT_W-1:0]   wr_addr;
  logic [CNT_W-1:0]   rd_left_addr;
  logic [CNT_W-1:0]   rd_right_addr;
  logic               elem_done;

  mx4_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .elem_done     (elem_done),
    .cmd           (cmd),
    .wr_addr       (wr_addr),
    .rd_left_addr  (rd_left_addr),
    .rd_right_addr (rd_right_addr)
  );

  mx4_dpath #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .left_value    (left_value),
    .right_value   (right_value),
    .cmd           (cmd),
    .wr_addr       (wr_addr),
    .rd_left_addr  (rd_left_addr),
    .rd_right_addr (rd_right_addr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .element_index (element_index),
    .result_value  (result_value),
    .saturated     (saturated),
    .last_element  (last_element),
    .elem_done     (elem_done)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for matrix4_add_sub_mul: random and directed matrix loads, checked
// against an in-bench model of add, subtract and Q16.16 product with saturation.
// Depends on hdl/mx4_pkg.sv and hdl/matrix4_add_sub_mul.sv.
`timescale 1ns / 1ps

module tb;

  localparam int DIM   = 4;
  localparam int FRAC  = 16;
  localparam int CELLS = DIM * DIM;
  localparam int NPH   = 9;

  localparam logic [mx4_pkg::MODE_W-1:0] MODE_ADD     = 2'd0;
  localparam logic [mx4_pkg::MODE_W-1:0] MODE_SUB     = 2'd1;
  localparam logic [mx4_pkg::MODE_W-1:0] MODE_MUL_ALT = 2'd3;  // high bit set: product too

  typedef struct {
    logic [mx4_pkg::DATA_W-1:0] lhs;
    logic [mx4_pkg::DATA_W-1:0] rhs;
  } elem_pair_t;

  typedef struct {
    logic [mx4_pkg::IDX_W-1:0]         idx;
    logic signed [mx4_pkg::DATA_W-1:0] value;
    logic                              sat;
    logic                              last;
  } mx_result_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic signed [mx4_pkg::DATA_W-1:0] left_value = '0;
  logic signed [mx4_pkg::DATA_W-1:0] right_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [mx4_pkg::IDX_W-1:0]         element_index;
  logic signed [mx4_pkg::DATA_W-1:0] result_value;
  logic                              saturated;
  logic                              last_element;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [mx4_pkg::MODE_W-1:0]        cfg_data = '0;

  matrix4_add_sub_mul dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_value   (left_value),
    .right_value  (right_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .element_index(element_index),
    .result_value (result_value),
    .saturated    (saturated),
    .last_element (last_element),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model state
  logic signed [mx4_pkg::DATA_W-1:0] lhs_mat [CELLS];
  logic signed [mx4_pkg::DATA_W-1:0] rhs_mat [CELLS];
  int                                load_pos = 0;
  logic [mx4_pkg::MODE_W-1:0]        mode_now = mx4_pkg::MODE_MUL;

  elem_pair_t pending[$];
  mx_result_t results_due[$];

  int n_issued = 0;
  int n_sent   = 0;
  int n_errors = 0;
  int snd_idle = 28;
  int rcv_idle = 52;
  int hold_cnt = 0;
  bit hold_ask = 1'b0;

  function automatic logic [mx4_pkg::DATA_W-1:0] clip_q(input longint acc,
                                                        output logic sat);
    sat = 1'b1;
    if (acc > longint'(32'sh7FFF_FFFF)) return mx4_pkg::Q_MAX;
    if (acc < -longint'(64'sd2147483648)) return mx4_pkg::Q_MIN;
    sat = 1'b0;
    return acc[mx4_pkg::DATA_W-1:0];
  endfunction

  // Results of one completed load, mode taken when the last element arrives
  function automatic void compute_matrix();
    mx_result_t r;
    longint     acc;
    logic       sat;
    for (int i = 0; i < CELLS; i++) begin
      if (mode_now[mx4_pkg::MODE_MUL_BIT]) begin
        acc = 0;
        for (int k = 0; k < DIM; k++)
          acc += (longint'(lhs_mat[(i / DIM) * DIM + k]) *
                  longint'(rhs_mat[k * DIM + (i % DIM)])) >>> FRAC;
      end else if (mode_now[mx4_pkg::MODE_SUB_BIT]) begin
        acc = longint'(lhs_mat[i]) - longint'(rhs_mat[i]);
      end else begin
        acc = longint'(lhs_mat[i]) + longint'(rhs_mat[i]);
      end
      r.value = clip_q(acc, sat);
      r.sat   = sat;
      r.idx   = i[mx4_pkg::IDX_W-1:0];
      r.last  = (i == CELLS - 1);
      results_due.push_back(r);
    end
  endfunction

  function automatic logic [mx4_pkg::DATA_W-1:0] rand_elem();
    case ($urandom_range(9))
      0, 1: begin
        case ($urandom_range(6))
          0: return mx4_pkg::Q_MAX;
          1: return mx4_pkg::Q_MIN;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          4: return 32'hFFFF_FFFF;
          5: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      2, 3, 4: return $urandom_range(32'h7FFFF) - 32'h40000;        // about +/-4.0
      5, 6:    return $urandom_range(32'h1FF_FFFF) - 32'h100_0000;  // about +/-256
      default: return $urandom();
    endcase
  endfunction

  // input transactions
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      lhs_mat[load_pos] = left_value;
      rhs_mat[load_pos] = right_value;
      n_sent++;
      load_pos++;
      if (load_pos == CELLS) begin
        load_pos = 0;
        compute_matrix();
      end
    end
  end

  // driver
  always @(negedge clk) begin : drive_in
    elem_pair_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && n_sent != n_issued) begin
      // hold until taken
    end else if (pending.size() != 0 && $urandom_range(99) >= snd_idle) begin
      nxt = pending.pop_front();
      left_value  <= nxt.lhs;
      right_value <= nxt.rhs;
      in_valid    <= 1'b1;
      n_issued++;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // long output stall, owned here
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
    end else if (hold_ask) begin
      hold_ask = 1'b0;
      hold_cnt = 400;
    end
  end

  always @(negedge clk) begin
    if (rst || hold_cnt > 0) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  // monitor
  always @(posedge clk) begin : mon
    mx_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with none pending: idx %0d value %h",
                 $time, element_index, result_value);
        n_errors++;
      end else begin
        want = results_due.pop_front();
        if (element_index !== want.idx) begin
          $display("%0t: element_index expected %0d got %0d", $time, want.idx, element_index);
          n_errors++;
        end
        if (result_value !== want.value) begin
          $display("%0t: result_value idx %0d expected %h got %h",
                   $time, want.idx, want.value, result_value);
          n_errors++;
        end
        if (saturated !== want.sat) begin
          $display("%0t: saturated idx %0d expected %b got %b",
                   $time, want.idx, want.sat, saturated);
          n_errors++;
        end
        if (last_element !== want.last) begin
          $display("%0t: last_element idx %0d expected %b got %b",
                   $time, want.idx, want.last, last_element);
          n_errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending.size() != 0 || n_sent != n_issued || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_mode(input logic [mx4_pkg::MODE_W-1:0] m);
    @(negedge clk);
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    mode_now = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++)
      pending.push_back('{rand_elem(), rand_elem()});
  endtask

  localparam logic [mx4_pkg::DATA_W-1:0] DIR_L [CELLS] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
    32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_8000, 32'hFFFE_8000,
    32'h8000_0000, 32'h0000_0007, 32'h0000_0000, 32'h7FFF_FFFF};
  localparam logic [mx4_pkg::DATA_W-1:0] DIR_R [CELLS] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
    32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000, 32'h0001_0000,
    32'h8000_0000, 32'h0000_0000, 32'h0002_0000, 32'hFFFF_8000,
    32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001};
  // sign and boundary cases for add/subtract
  localparam logic [mx4_pkg::DATA_W-1:0] EDGE_L [8] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF};
  localparam logic [mx4_pkg::DATA_W-1:0] EDGE_R [8] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF};

  localparam logic [mx4_pkg::MODE_W-1:0] PHASE_MODE [NPH] = '{
    MODE_SUB, MODE_MUL_ALT, MODE_ADD, mx4_pkg::MODE_MUL, MODE_SUB,
    mx4_pkg::MODE_MUL, MODE_MUL_ALT, MODE_ADD, mx4_pkg::MODE_MUL};
  localparam int PHASE_LEN [NPH] = '{8, 16, 20, 12, 16, 32, 16, 16, 16};

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // product in the reset mode, extreme operands
    for (int i = 0; i < CELLS; i++) pending.push_back('{DIR_L[i], DIR_R[i]});
    wait_drained();

    // half a load in add mode; the mode change mid-load makes it a subtract run
    write_mode(MODE_ADD);
    @(posedge clk);
    for (int i = 0; i < 8; i++) pending.push_back('{EDGE_L[i], EDGE_R[i]});

    for (int p = 0; p < NPH; p++) begin
      wait_drained();
      if (p < 3) begin
        snd_idle = 28; rcv_idle = 52;
      end else if (p < 6) begin
        snd_idle = 52; rcv_idle = 28;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      write_mode(PHASE_MODE[p]);
      if (p == 5) hold_ask = 1'b1;  // stall the sink while two loads are offered
      @(posedge clk);
      if (p == NPH - 1) begin
        // sender pauses mid-load until everything pending has drained
        queue_random(8);
        wait_drained();
        queue_random(8);
      end else begin
        queue_random(PHASE_LEN[p]);
      end
    end

    wait_drained();
    if (n_errors == 0) begin
      $display("** matrix4_add_sub_mul: PASSED **");
    end else begin
      $display("** matrix4_add_sub_mul: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("** matrix4_add_sub_mul: FAILED **");
    $finish;
  end

endmodule
